// File: hdl/dram_bank_timing_fsm_defines.svh
// ----------------------------------------------------------------------------
// dram bank timing fsm assertion macros
// shared concurrent assertion shorthands, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef DRAM_BANK_TIMING_FSM_DEFINES_SVH
`define DRAM_BANK_TIMING_FSM_DEFINES_SVH

// same-cycle implication
`define DBT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dbt assertion failed");

// next-cycle implication
`define DBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dbt assertion failed");

`endif

// File: hdl/dbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbt_pkg
// types, codes and constants shared by the dram bank timing blocks
// ----------------------------------------------------------------------------
package dbt_pkg;

  // completion queue sizing
  localparam int QUEUE_DEPTH = 8;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // fixed turnaround and auto-precharge delays
  localparam int READ_TO_PRECHARGE    = 6;
  localparam int WRITE_TO_PRECHARGE   = 16;
  localparam int READ_AUTO_PRE_DELAY  = 20;
  localparam int WRITE_AUTO_PRE_DELAY = 30;

  localparam logic [10:0] SINCE_MAX = 11'd2047;

  // command codes
  localparam logic [2:0] CMD_ACT   = 3'd0;
  localparam logic [2:0] CMD_RD    = 3'd1;
  localparam logic [2:0] CMD_RD_AP = 3'd2;
  localparam logic [2:0] CMD_WR    = 3'd3;
  localparam logic [2:0] CMD_WR_AP = 3'd4;
  localparam logic [2:0] CMD_PRE   = 3'd5;
  localparam logic [2:0] CMD_REF   = 3'd6;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_IDLE_CMD  = 2'd1;
  localparam logic [1:0] ERR_ACTIVE_CMD = 2'd2;
  localparam logic [1:0] ERR_ROW       = 2'd3;

  // register indexes
  localparam int NUM_REGS = 8;
  localparam logic [2:0] REG_ACT_DELAY = 3'd0;
  localparam logic [2:0] REG_REF_DELAY = 3'd1;
  localparam logic [2:0] REG_PRE_DELAY = 3'd2;
  localparam logic [2:0] REG_RD_RD     = 3'd3;
  localparam logic [2:0] REG_WR_RD     = 3'd4;
  localparam logic [2:0] REG_RD_WR     = 3'd5;
  localparam logic [2:0] REG_WR_WR     = 3'd6;
  localparam logic [2:0] REG_RD_LAT    = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_ACTIVATING  = 3'd1,
    ST_ACTIVE      = 3'd2,
    ST_REFRESHING  = 3'd3,
    ST_PRECHARGING = 3'd4
  } bank_state_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [2:0]  mode;
    logic [15:0] row;
    logic [15:0] tag;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic        done_valid;
    logic [15:0] done_tag;
    logic        error_valid;
    logic [1:0]  error_code;
    logic [2:0]  bank_status;
    logic [15:0] open_row_out;
    logic [3:0]  reads_pending;
  } out_word_t;

  typedef struct packed {
    logic [9:0] activate_delay;
    logic [9:0] refresh_delay;
    logic [9:0] precharge_delay;
    logic [9:0] read_after_read;
    logic [9:0] read_after_write;
    logic [9:0] write_after_read;
    logic [9:0] write_after_write;
    logic [9:0] read_latency;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    activate_delay:    10'd14,
    refresh_delay:     10'd350,
    precharge_delay:   10'd14,
    read_after_read:   10'd4,
    read_after_write:  10'd20,
    write_after_read:  10'd8,
    write_after_write: 10'd4,
    read_latency:      10'd18
  };

  // bank to completion queue
  typedef struct packed {
    logic        push;
    logic [9:0]  due;
    logic [15:0] tag;
  } push_t;

  // completion queue head report
  typedef struct packed {
    logic        valid;
    logic [15:0] tag;
  } done_t;

  // bank per-tick outcome
  typedef struct packed {
    logic        accepted;
    logic [1:0]  err;
    bank_state_t mode;
    logic [15:0] open_row;
  } bank_res_t;

endpackage

// File: hdl/dbt_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbt_regs
// apb timing register file, eight 10-bit registers at word addresses
// ----------------------------------------------------------------------------
module dbt_regs import dbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_ACT_DELAY: cfg.activate_delay    <= pwdata[9:0];
        REG_REF_DELAY: cfg.refresh_delay     <= pwdata[9:0];
        REG_PRE_DELAY: cfg.precharge_delay   <= pwdata[9:0];
        REG_RD_RD:     cfg.read_after_read   <= pwdata[9:0];
        REG_WR_RD:     cfg.read_after_write  <= pwdata[9:0];
        REG_RD_WR:     cfg.write_after_read  <= pwdata[9:0];
        REG_WR_WR:     cfg.write_after_write <= pwdata[9:0];
        REG_RD_LAT:    cfg.read_latency      <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    prdata = '0;
    case (idx)
      REG_ACT_DELAY: prdata[9:0] = cfg.activate_delay;
      REG_REF_DELAY: prdata[9:0] = cfg.refresh_delay;
      REG_PRE_DELAY: prdata[9:0] = cfg.precharge_delay;
      REG_RD_RD:     prdata[9:0] = cfg.read_after_read;
      REG_WR_RD:     prdata[9:0] = cfg.read_after_write;
      REG_RD_WR:     prdata[9:0] = cfg.write_after_read;
      REG_WR_WR:     prdata[9:0] = cfg.write_after_write;
      REG_RD_LAT:    prdata[9:0] = cfg.read_latency;
      default:       prdata = '0;
    endcase
  end

endmodule

// File: hdl/dbt_queue.sv
`timescale 1ns / 1ps
`include "dram_bank_timing_fsm_defines.svh"
// ----------------------------------------------------------------------------
// dbt_queue
// read completion queue: per-entry countdown, head pops when it reaches zero
// ----------------------------------------------------------------------------
module dbt_queue import dbt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          tick,
  input  push_t         push_in,
  output done_t         done,
  output logic [CW-1:0] count_after,
  output logic [CW-1:0] count_next
);

  logic [9:0]    due_left [QUEUE_DEPTH];
  logic [15:0]   due_tag  [QUEUE_DEPTH];
  logic [CW-1:0] count;

  logic [9:0]    dec      [QUEUE_DEPTH];
  logic [9:0]    sh_left  [QUEUE_DEPTH];
  logic [15:0]   sh_tag   [QUEUE_DEPTH];
  logic          pop;
  logic [QW-1:0] wr_idx;

  // count down every entry, pop the head when due
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      dec[i] = (due_left[i] != 10'd0) ? due_left[i] - 10'd1 : 10'd0;
    end
    pop = (count != '0) && (dec[0] == 10'd0);
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      if (pop) begin
        sh_left[i] = dec[i + 1];
        sh_tag[i]  = due_tag[i + 1];
      end else begin
        sh_left[i] = dec[i];
        sh_tag[i]  = due_tag[i];
      end
    end
    // last entry only ever moves down
    sh_left[QUEUE_DEPTH - 1] = dec[QUEUE_DEPTH - 1];
    sh_tag[QUEUE_DEPTH - 1]  = due_tag[QUEUE_DEPTH - 1];
  end

  assign count_after = count - CW'(pop);
  assign count_next  = count_after + CW'(push_in.push);
  assign wr_idx      = count_after[QW-1:0];
  assign done.valid  = pop;
  assign done.tag    = due_tag[0];

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (tick) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (push_in.push && (wr_idx == QW'(i))) begin
          due_left[i] <= push_in.due;
          due_tag[i]  <= push_in.tag;
        end else begin
          due_left[i] <= sh_left[i];
          due_tag[i]  <= sh_tag[i];
        end
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (tick) begin
      count <= count_next;
    end
  end

  `DBT_ASSERT_NOW(a_push_has_room, tick && push_in.push, count_after < CW'(QUEUE_DEPTH))
  `DBT_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(QUEUE_DEPTH))

endmodule

// File: hdl/dbt_bank.sv
`timescale 1ns / 1ps
`include "dram_bank_timing_fsm_defines.svh"
// ----------------------------------------------------------------------------
// dbt_bank
// bank state machine with command slot, timed waits and column turnaround
// ----------------------------------------------------------------------------
module dbt_bank import dbt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          tick,
  input  in_word_t      word,
  input  cfg_t          cfg,
  input  logic [CW-1:0] q_count_after,
  output push_t         push_out,
  output bank_res_t     res
);

  bank_state_t mode, mode_next;
  logic [15:0] open_row, open_row_next;
  logic        slot_full, slot_full_next;
  logic [2:0]  slot_cmd, slot_cmd_next;
  logic [15:0] slot_row, slot_row_next;
  logic [15:0] slot_tag, slot_tag_next;
  logic [9:0]  wait_left, wait_left_next;
  logic [10:0] since_column, since_column_next;
  logic        last_was_read, last_was_read_next;

  logic        accepted;
  logic [1:0]  err;
  logic [10:0] need;
  logic        q_full;

  assign q_full = q_count_after >= CW'(QUEUE_DEPTH);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= ST_IDLE;
      open_row      <= '0;
      slot_full     <= 1'b0;
      slot_cmd      <= CMD_ACT;
      slot_row      <= '0;
      slot_tag      <= '0;
      wait_left     <= '0;
      since_column  <= '0;
      last_was_read <= 1'b0;
    end else if (tick) begin
      mode          <= mode_next;
      open_row      <= open_row_next;
      slot_full     <= slot_full_next;
      slot_cmd      <= slot_cmd_next;
      slot_row      <= slot_row_next;
      slot_tag      <= slot_tag_next;
      wait_left     <= wait_left_next;
      since_column  <= since_column_next;
      last_was_read <= last_was_read_next;
    end
  end

  // next state and per-tick outcome
  always_comb begin
    mode_next          = mode;
    open_row_next      = open_row;
    slot_cmd_next      = slot_cmd;
    slot_row_next      = slot_row;
    slot_tag_next      = slot_tag;
    last_was_read_next = last_was_read;
    accepted           = 1'b0;
    err                = ERR_NONE;
    need               = '0;
    push_out.push      = 1'b0;
    push_out.due       = cfg.read_latency;

    // free-running counters
    since_column_next = (since_column == SINCE_MAX) ? since_column : since_column + 11'd1;
    wait_left_next    = (wait_left != 10'd0) ? wait_left - 10'd1 : 10'd0;

    // slot fill
    slot_full_next = slot_full;
    if (word.cmd_valid && !slot_full) begin
      accepted       = 1'b1;
      slot_full_next = 1'b1;
      slot_cmd_next  = word.mode;
      slot_row_next  = word.row;
      slot_tag_next  = word.tag;
    end
    push_out.tag = slot_tag_next;

    if (wait_left_next == 10'd0) begin
      // timed states finish
      case (mode)
        ST_REFRESHING, ST_PRECHARGING: mode_next = ST_IDLE;
        ST_ACTIVATING:                 mode_next = ST_ACTIVE;
        default:                       mode_next = mode;
      endcase

      // serve the slot
      if (slot_full_next) begin
        slot_full_next = 1'b0;
        if (mode_next == ST_IDLE) begin
          case (slot_cmd_next)
            CMD_ACT: begin
              open_row_next  = slot_row_next;
              mode_next      = ST_ACTIVATING;
              wait_left_next = cfg.activate_delay;
            end
            CMD_REF: begin
              mode_next      = ST_REFRESHING;
              wait_left_next = cfg.refresh_delay;
            end
            default: err = ERR_IDLE_CMD;
          endcase
        end else begin
          case (slot_cmd_next)
            CMD_RD, CMD_RD_AP: begin
              need = {1'b0, last_was_read ? cfg.read_after_read : cfg.read_after_write};
              if (since_column_next < need || q_full) begin
                slot_full_next = 1'b1;
              end else if (slot_row_next != open_row) begin
                err = ERR_ROW;
              end else begin
                since_column_next  = '0;
                last_was_read_next = 1'b1;
                push_out.push      = 1'b1;
                if (slot_cmd_next == CMD_RD_AP) begin
                  mode_next      = ST_PRECHARGING;
                  wait_left_next = 10'(READ_AUTO_PRE_DELAY);
                end
              end
            end
            CMD_WR, CMD_WR_AP: begin
              need = {1'b0, last_was_read ? cfg.write_after_read : cfg.write_after_write};
              if (since_column_next < need) begin
                slot_full_next = 1'b1;
              end else if (slot_row_next != open_row) begin
                err = ERR_ROW;
              end else begin
                since_column_next  = '0;
                last_was_read_next = 1'b0;
                if (slot_cmd_next == CMD_WR_AP) begin
                  mode_next      = ST_PRECHARGING;
                  wait_left_next = 10'(WRITE_AUTO_PRE_DELAY);
                end
              end
            end
            CMD_PRE: begin
              need = last_was_read ? 11'(READ_TO_PRECHARGE) : 11'(WRITE_TO_PRECHARGE);
              if (since_column_next < need) begin
                slot_full_next = 1'b1;
              end else begin
                mode_next      = ST_PRECHARGING;
                wait_left_next = cfg.precharge_delay;
              end
            end
            default: err = ERR_ACTIVE_CMD;
          endcase
        end
      end
    end

    res.accepted = accepted;
    res.err      = err;
    res.mode     = mode_next;
    res.open_row = open_row_next;
  end

  `DBT_ASSERT_NOW(a_wait_only_timed, wait_left != 10'd0,
                  mode == ST_ACTIVATING || mode == ST_REFRESHING || mode == ST_PRECHARGING)
  `DBT_ASSERT_NEXT(a_slot_held_busy, tick && slot_full && wait_left > 10'd1,
                   slot_full && $stable(slot_cmd) && $stable(slot_row))

endmodule

// File: hdl/dram_bank_timing_fsm.sv
// output: the result word of an accepted tick word is registered in the output register
// throughput: one tick word per cycle; the next word enters while a result is being taken
// a stalled result holds the input side off until it is taken
// reset: synchronous, clears bank state, command slot and queue count, reloads timing defaults
`timescale 1ns / 1ps
`include "dram_bank_timing_fsm_defines.svh"
// ----------------------------------------------------------------------------
// dram_bank_timing_fsm
// dram bank state machine with timing checks and read completion reporting
// ----------------------------------------------------------------------------
module dram_bank_timing_fsm import dbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic          tick;
  cfg_t          cfg;
  push_t         push;
  done_t         done;
  bank_res_t     res;
  logic [CW-1:0] q_count_after;
  logic [CW-1:0] q_count_next;
  out_word_t     result;

  assign in_stall = out_valid && out_stall;
  assign tick     = in_valid && !in_stall;

  dbt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dbt_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .push_in     (push),
    .done        (done),
    .count_after (q_count_after),
    .count_next  (q_count_next)
  );

  dbt_bank u_bank (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .word          (in_data),
    .cfg           (cfg),
    .q_count_after (q_count_after),
    .push_out      (push),
    .res           (res)
  );

  // result word assembly
  always_comb begin
    result.accepted      = res.accepted;
    result.done_valid    = done.valid;
    result.done_tag      = done.valid ? done.tag : 16'd0;
    result.error_valid   = (res.err != ERR_NONE);
    result.error_code    = res.err;
    result.bank_status   = res.mode;
    result.open_row_out  = res.open_row;
    result.reads_pending = 4'(q_count_next);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_data <= result;
    end
  end

  `DBT_ASSERT_NOW(a_done_tag_zero, out_valid && !out_data.done_valid, out_data.done_tag == 16'd0)
  `DBT_ASSERT_NOW(a_err_code_match, out_valid,
                  out_data.error_valid == (out_data.error_code != ERR_NONE))

endmodule
